// ===== hw/rtl/hgfc_pkg.sv =====
// Package for the hex grid face connectivity block: widths, stage map,
// face group codes and config register indexes. No dependencies.
package hgfc_pkg;

    localparam int MAX_CELLS_PER_AXIS = 256;

    localparam int AXW = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int IW  = $clog2(MAX_CELLS_PER_AXIS);
    localparam int PW  = $clog2(MAX_CELLS_PER_AXIS + 2);
    localparam int NXY_W = 2 * AXW;
    localparam int PXY_W = 2 * PW;

    localparam int FACE_W = 26;
    localparam int GRP_W  = 4;
    localparam int CELL_W = 24;
    localparam int PT_W   = 25;
    localparam int HALF_W = 10;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 9;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 184;
    localparam int M_USER_W = 6;

    localparam int NUM_GROUPS = 9;
    localparam int CNT_W      = 3 * AXW;
    localparam int BND_W      = CNT_W + $clog2(NUM_GROUPS);

    localparam int RW    = FACE_W;
    localparam int Q2W   = $clog2(MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS);
    localparam int DIV_K = 4;
    localparam int N1    = (RW + DIV_K - 1) / DIV_K;
    localparam int N2    = (Q2W + DIV_K - 1) / DIV_K;
    localparam int D1W   = N1 * DIV_K;
    localparam int D2W   = N2 * DIV_K;

    localparam int ST_A  = 0;
    localparam int ST_B  = 1;
    localparam int ST_D1 = 2;
    localparam int ST_D2 = ST_D1 + N1;
    localparam int ST_C  = ST_D2 + N2;
    localparam int ST_M1 = ST_C + 1;
    localparam int ST_M2 = ST_M1 + 1;
    localparam int ST_O  = ST_M2 + 1;
    localparam int NS    = ST_O + 1;

    localparam int SETTLE   = NUM_GROUPS + 5;
    localparam int SETTLE_W = $clog2(SETTLE + 1);

    localparam logic [CFG_AW-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CELLS_Z = 2'd2;

    typedef enum logic [GRP_W-1:0] {
        G_INT_X  = 4'd0,
        G_INT_Y  = 4'd1,
        G_INT_Z  = 4'd2,
        G_LEFT   = 4'd3,
        G_RIGHT  = 4'd4,
        G_BOTTOM = 4'd5,
        G_TOP    = 4'd6,
        G_FRONT  = 4'd7,
        G_BACK   = 4'd8
    } t_group;

    typedef struct packed {
        t_group grp;
        logic   found;
    } t_meta;

endpackage

// ===== hw/rtl/hex_grid_face_connectivity.sv =====
// Top level of the hex grid face connectivity block: face number in,
// group, cells, corner points and centre out. Depends on hgfc_pkg.
// Throughput: one word per cycle while the receiver takes words and ready is not
// held low for settling; stages move independently, so bubbles close up.
// The two pipelined restoring dividers (4 quotient bits a stage) set the depth.
// After reset and after any config write, o_s_tready stays low while the
// group counts and their running sums settle through their registers.
// Reset is synchronous, active low; it empties the pipe and sets each axis to 1.
module hex_grid_face_connectivity (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hgfc_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [hgfc_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // face_number
    input  logic [hgfc_pkg::S_DATA_W-1:0]  i_s_tdata,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // owner_cell, neighbour_cell, corner_a, corner_b, corner_c, corner_d,
    // centre_x_half, centre_y_half, centre_z_half, zero pad
    output logic [hgfc_pkg::M_DATA_W-1:0]  o_m_tdata,
    // face_group, has_neighbour, out_of_range
    output logic [hgfc_pkg::M_USER_W-1:0]  o_m_tuser
);
    import hgfc_pkg::*;

    function automatic logic [AXW-1:0] eff_axis(input logic [CFG_DW-1:0] v);
        logic [AXW-1:0] r;
        if (v == '0) begin
            r = AXW'(1);
        end else if (AXW'(v) > AXW'(MAX_CELLS_PER_AXIS)) begin
            r = AXW'(MAX_CELLS_PER_AXIS);
        end else begin
            r = AXW'(v);
        end
        return r;
    endfunction

    logic [CFG_DW-1:0]   r_cx, r_cy, r_cz;
    logic [SETTLE_W-1:0] r_set;

    logic [AXW-1:0]   r_nx, r_ny, r_nz;
    logic [PW-1:0]    r_px;
    logic [2*AXW-1:0] r_nxy;
    logic [2*PW-1:0]  r_pxy;
    logic [2*AXW-1:0] r_ab  [NUM_GROUPS];
    logic [AXW-1:0]   r_c   [NUM_GROUPS];
    logic [CNT_W-1:0] r_cnt [NUM_GROUPS];
    logic [BND_W-1:0] r_bnd [NUM_GROUPS];

    logic [AXW-1:0] n_a [NUM_GROUPS];
    logic [AXW-1:0] n_b [NUM_GROUPS];
    logic [AXW-1:0] n_c [NUM_GROUPS];

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= CFG_DW'(1);
            r_cy  <= CFG_DW'(1);
            r_cz  <= CFG_DW'(1);
            r_set <= SETTLE_W'(SETTLE);
        end else if (i_cfg_we) begin
            r_set <= SETTLE_W'(SETTLE);
            case (i_cfg_addr)
                CFG_CELLS_X: r_cx <= i_cfg_wdata;
                CFG_CELLS_Y: r_cy <= i_cfg_wdata;
                CFG_CELLS_Z: r_cz <= i_cfg_wdata;
                default: ;
            endcase
        end else if (r_set != '0) begin
            r_set <= r_set - 1'b1;
        end
    end

    always_comb begin
        n_a[G_INT_X] = r_nx - 1'b1; n_b[G_INT_X] = r_ny;        n_c[G_INT_X] = r_nz;
        n_a[G_INT_Y] = r_nx;        n_b[G_INT_Y] = r_ny - 1'b1; n_c[G_INT_Y] = r_nz;
        n_a[G_INT_Z] = r_nx;        n_b[G_INT_Z] = r_ny;        n_c[G_INT_Z] = r_nz - 1'b1;
        n_a[G_LEFT]   = r_ny; n_b[G_LEFT]   = r_nz; n_c[G_LEFT]   = AXW'(1);
        n_a[G_RIGHT]  = r_ny; n_b[G_RIGHT]  = r_nz; n_c[G_RIGHT]  = AXW'(1);
        n_a[G_BOTTOM] = r_nx; n_b[G_BOTTOM] = r_nz; n_c[G_BOTTOM] = AXW'(1);
        n_a[G_TOP]    = r_nx; n_b[G_TOP]    = r_nz; n_c[G_TOP]    = AXW'(1);
        n_a[G_FRONT]  = r_nx; n_b[G_FRONT]  = r_ny; n_c[G_FRONT]  = AXW'(1);
        n_a[G_BACK]   = r_nx; n_b[G_BACK]   = r_ny; n_c[G_BACK]   = AXW'(1);
    end

    always_ff @(posedge i_clk) begin
        r_nx  <= eff_axis(r_cx);
        r_ny  <= eff_axis(r_cy);
        r_nz  <= eff_axis(r_cz);
        r_px  <= PW'(r_nx) + 1'b1;
        r_nxy <= r_nx * r_ny;
        r_pxy <= (PW'(r_nx) + 1'b1) * (PW'(r_ny) + 1'b1);
        for (int g = 0; g < NUM_GROUPS; g++) begin
            r_ab[g]  <= n_a[g] * n_b[g];
            r_c[g]   <= n_c[g];
            r_cnt[g] <= r_ab[g] * r_c[g];
        end
        r_bnd[0] <= BND_W'(r_cnt[0]);
        for (int g = 1; g < NUM_GROUPS; g++) begin
            r_bnd[g] <= r_bnd[g-1] + BND_W'(r_cnt[g]);
        end
    end

    // stage enables: load when empty or when the word ahead moves on
    always_comb begin
        en[NS-1] = !r_v[NS-1] || i_m_tready;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_s_tready = en[0] && (r_set == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_s_tvalid && o_s_tready;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage A: compare against running group bounds
    logic [FACE_W-1:0]     r_fa;
    logic [NUM_GROUPS-1:0] r_lt;
    logic [FACE_W-1:0]     n_face;

    assign n_face = i_s_tdata[FACE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en[ST_A]) begin
            r_fa <= n_face;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_lt[g] <= BND_W'(n_face) < r_bnd[g];
            end
        end
    end

    // stage B: pick group, subtract its base, select divisors
    logic [GRP_W-1:0] n_sel;
    logic [BND_W-1:0] n_base;
    t_meta            n_bm;
    logic [AXW-1:0]   n_da, n_db;
    logic [RW-1:0]    r_sb_local;
    logic [AXW-1:0]   r_sb_a, r_sb_b;
    t_meta            r_sb_m;

    always_comb begin
        n_sel  = '0;
        n_base = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (!r_lt[g]) begin
                n_sel = n_sel + 1'b1;
            end
        end
        for (int g = 1; g < NUM_GROUPS; g++) begin
            if (r_lt[g] && !r_lt[g-1]) begin
                n_base = r_bnd[g-1];
            end
        end
        n_bm.found = r_lt[NUM_GROUPS-1];
        n_bm.grp   = n_bm.found ? t_group'(n_sel) : G_INT_X;
        n_da = n_a[n_bm.grp];
        n_db = n_b[n_bm.grp];
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_B]) begin
            r_sb_local <= RW'(BND_W'(r_fa) - n_base);
            r_sb_a     <= n_da;
            r_sb_b     <= n_db;
            r_sb_m     <= n_bm;
        end
    end

    // first divider: local / a
    logic [AXW-1:0] r_d1_rem [N1];
    logic [D1W-1:0] r_d1_dvd [N1];
    logic [AXW-1:0] r_d1_a   [N1];
    logic [AXW-1:0] r_d1_b   [N1];
    t_meta          r_d1_m   [N1];

    for (genvar s = 0; s < N1; s++) begin : g_d1
        logic [AXW-1:0] n_rem, in_rem, in_a, in_b;
        logic [D1W-1:0] n_dvd, in_dvd;
        logic [AXW:0]   t2;
        t_meta          in_m;
        if (s == 0) begin : g_first
            assign in_rem = '0;
            assign in_dvd = D1W'(r_sb_local);
            assign in_a   = r_sb_a;
            assign in_b   = r_sb_b;
            assign in_m   = r_sb_m;
        end else begin : g_next
            assign in_rem = r_d1_rem[s-1];
            assign in_dvd = r_d1_dvd[s-1];
            assign in_a   = r_d1_a[s-1];
            assign in_b   = r_d1_b[s-1];
            assign in_m   = r_d1_m[s-1];
        end
        always_comb begin
            n_rem = in_rem;
            n_dvd = in_dvd;
            t2    = '0;
            for (int t = 0; t < DIV_K; t++) begin
                t2 = {n_rem, n_dvd[D1W-1]};
                if (t2 >= {1'b0, in_a}) begin
                    n_rem = AXW'(t2 - {1'b0, in_a});
                    n_dvd = {n_dvd[D1W-2:0], 1'b1};
                end else begin
                    n_rem = t2[AXW-1:0];
                    n_dvd = {n_dvd[D1W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[ST_D1+s]) begin
                r_d1_rem[s] <= n_rem;
                r_d1_dvd[s] <= n_dvd;
                r_d1_a[s]   <= in_a;
                r_d1_b[s]   <= in_b;
                r_d1_m[s]   <= in_m;
            end
        end
    end

    // second divider: quotient / b
    logic [AXW-1:0] r_d2_rem [N2];
    logic [D2W-1:0] r_d2_dvd [N2];
    logic [AXW-1:0] r_d2_b   [N2];
    logic [IW-1:0]  r_d2_u   [N2];
    t_meta          r_d2_m   [N2];

    for (genvar s = 0; s < N2; s++) begin : g_d2
        logic [AXW-1:0] n_rem, in_rem, in_b;
        logic [D2W-1:0] n_dvd, in_dvd;
        logic [AXW:0]   t2;
        logic [IW-1:0]  in_u;
        t_meta          in_m;
        if (s == 0) begin : g_first
            assign in_rem = '0;
            assign in_dvd = D2W'(r_d1_dvd[N1-1][Q2W-1:0]);
            assign in_b   = r_d1_b[N1-1];
            assign in_u   = r_d1_rem[N1-1][IW-1:0];
            assign in_m   = r_d1_m[N1-1];
        end else begin : g_next
            assign in_rem = r_d2_rem[s-1];
            assign in_dvd = r_d2_dvd[s-1];
            assign in_b   = r_d2_b[s-1];
            assign in_u   = r_d2_u[s-1];
            assign in_m   = r_d2_m[s-1];
        end
        always_comb begin
            n_rem = in_rem;
            n_dvd = in_dvd;
            t2    = '0;
            for (int t = 0; t < DIV_K; t++) begin
                t2 = {n_rem, n_dvd[D2W-1]};
                if (t2 >= {1'b0, in_b}) begin
                    n_rem = AXW'(t2 - {1'b0, in_b});
                    n_dvd = {n_dvd[D2W-2:0], 1'b1};
                end else begin
                    n_rem = t2[AXW-1:0];
                    n_dvd = {n_dvd[D2W-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en[ST_D2+s]) begin
                r_d2_rem[s] <= n_rem;
                r_d2_dvd[s] <= n_dvd;
                r_d2_b[s]   <= in_b;
                r_d2_u[s]   <= in_u;
                r_d2_m[s]   <= in_m;
            end
        end
    end

    // stage C: place i, j, k by group
    logic [IW-1:0] n_u, n_vv, n_w, n_i, n_j, n_k;
    logic [IW-1:0] r_c_i, r_c_j, r_c_k;
    t_meta         r_c_m;

    assign n_u  = r_d2_u[N2-1];
    assign n_vv = r_d2_rem[N2-1][IW-1:0];
    assign n_w  = r_d2_dvd[N2-1][IW-1:0];

    always_comb begin
        n_i = n_u;
        n_j = n_vv;
        n_k = n_w;
        case (r_d2_m[N2-1].grp)
            G_INT_X, G_INT_Y, G_INT_Z: ;
            G_LEFT:   begin n_i = '0;                  n_j = n_u;  n_k = n_vv; end
            G_RIGHT:  begin n_i = IW'(r_nx - 1'b1);    n_j = n_u;  n_k = n_vv; end
            G_BOTTOM: begin n_j = '0;                  n_k = n_vv; end
            G_TOP:    begin n_j = IW'(r_ny - 1'b1);    n_k = n_vv; end
            G_FRONT:  begin n_k = '0; end
            G_BACK:   begin n_k = IW'(r_nz - 1'b1); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_C]) begin
            r_c_i <= n_i;
            r_c_j <= n_j;
            r_c_k <= n_k;
            r_c_m <= r_d2_m[N2-1];
        end
    end

    // stage M1: products and per-group steps
    logic [IW+2*AXW-1:0] r_m1_kxy;
    logic [IW+AXW-1:0]   r_m1_jx;
    logic [IW+2*PW-1:0]  r_m1_kp;
    logic [IW+PW-1:0]    r_m1_jp;
    logic [2*PW-1:0]     r_m1_off, r_m1_s1, r_m1_s2, n_off, n_s1, n_s2;
    logic [2*AXW-1:0]    r_m1_ns, n_ns;
    logic [IW-1:0]       r_m1_i, r_m1_j, r_m1_k;
    t_meta               r_m1_m;

    always_comb begin
        n_off = '0;
        n_ns  = '0;
        n_s1  = PXY_W'(1);
        n_s2  = r_pxy;
        case (r_c_m.grp)
            G_INT_X:  begin n_off = PXY_W'(1);    n_ns = NXY_W'(1);
                            n_s1 = PXY_W'(r_px); end
            G_INT_Y:  begin n_off = PXY_W'(r_px); n_ns = NXY_W'(r_nx); end
            G_INT_Z:  begin n_off = r_pxy;        n_ns = r_nxy;
                            n_s2 = PXY_W'(r_px); end
            G_LEFT:   begin n_s1 = PXY_W'(r_px); end
            G_RIGHT:  begin n_off = PXY_W'(1);    n_s1 = PXY_W'(r_px); end
            G_BOTTOM: ;
            G_TOP:    begin n_off = PXY_W'(r_px); end
            G_FRONT:  begin n_s2 = PXY_W'(r_px); end
            G_BACK:   begin n_off = r_pxy;        n_s2 = PXY_W'(r_px); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M1]) begin
            r_m1_kxy <= r_c_k * r_nxy;
            r_m1_jx  <= r_c_j * r_nx;
            r_m1_kp  <= r_c_k * r_pxy;
            r_m1_jp  <= r_c_j * r_px;
            r_m1_off <= n_off;
            r_m1_s1  <= n_s1;
            r_m1_s2  <= n_s2;
            r_m1_ns  <= n_ns;
            r_m1_i   <= r_c_i;
            r_m1_j   <= r_c_j;
            r_m1_k   <= r_c_k;
            r_m1_m   <= r_c_m;
        end
    end

    // stage M2: owner cell and base point
    logic [CELL_W-1:0] r_m2_own;
    logic [PT_W-1:0]   r_m2_p;
    logic [2*PW-1:0]   r_m2_s1, r_m2_s2;
    logic [2*PW:0]     r_m2_s12;
    logic [2*AXW-1:0]  r_m2_ns;
    logic [IW-1:0]     r_m2_i, r_m2_j, r_m2_k;
    t_meta             r_m2_m;

    always_ff @(posedge i_clk) begin
        if (en[ST_M2]) begin
            r_m2_own <= CELL_W'(r_m1_kxy + CELL_W'(r_m1_jx) + CELL_W'(r_m1_i));
            r_m2_p   <= PT_W'(r_m1_kp + PT_W'(r_m1_jp) + PT_W'(r_m1_i) + PT_W'(r_m1_off));
            r_m2_s1  <= r_m1_s1;
            r_m2_s2  <= r_m1_s2;
            r_m2_s12 <= {1'b0, r_m1_s1} + {1'b0, r_m1_s2};
            r_m2_ns  <= r_m1_ns;
            r_m2_i   <= r_m1_i;
            r_m2_j   <= r_m1_j;
            r_m2_k   <= r_m1_k;
            r_m2_m   <= r_m1_m;
        end
    end

    // stage O: corners, neighbour, centre
    logic [GRP_W-1:0]  r_o_grp;
    logic [CELL_W-1:0] r_o_own, r_o_nb;
    logic              r_o_hn, r_o_oor;
    logic [PT_W-1:0]   r_o_ca, r_o_cb, r_o_cc, r_o_cd;
    logic [HALF_W-1:0] r_o_hx, r_o_hy, r_o_hz, n_hx, n_hy, n_hz;
    logic              n_int;

    assign n_int = (r_m2_m.grp == G_INT_X) || (r_m2_m.grp == G_INT_Y) ||
                   (r_m2_m.grp == G_INT_Z);

    always_comb begin
        n_hx = HALF_W'({r_m2_i, 1'b1});
        n_hy = HALF_W'({r_m2_j, 1'b1});
        n_hz = HALF_W'({r_m2_k, 1'b1});
        case (r_m2_m.grp)
            G_INT_X:  n_hx = HALF_W'({r_m2_i, 1'b0}) + HALF_W'(2);
            G_INT_Y:  n_hy = HALF_W'({r_m2_j, 1'b0}) + HALF_W'(2);
            G_INT_Z:  n_hz = HALF_W'({r_m2_k, 1'b0}) + HALF_W'(2);
            G_LEFT:   n_hx = '0;
            G_RIGHT:  n_hx = HALF_W'({r_nx, 1'b0});
            G_BOTTOM: n_hy = '0;
            G_TOP:    n_hy = HALF_W'({r_ny, 1'b0});
            G_FRONT:  n_hz = '0;
            G_BACK:   n_hz = HALF_W'({r_nz, 1'b0});
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_O]) begin
            if (r_m2_m.found) begin
                r_o_grp <= r_m2_m.grp;
                r_o_own <= r_m2_own;
                r_o_nb  <= n_int ? CELL_W'(r_m2_own + CELL_W'(r_m2_ns)) : '0;
                r_o_hn  <= n_int;
                r_o_ca  <= r_m2_p;
                r_o_cb  <= PT_W'(r_m2_p + PT_W'(r_m2_s1));
                r_o_cc  <= PT_W'(r_m2_p + PT_W'(r_m2_s12));
                r_o_cd  <= PT_W'(r_m2_p + PT_W'(r_m2_s2));
                r_o_hx  <= n_hx;
                r_o_hy  <= n_hy;
                r_o_hz  <= n_hz;
                r_o_oor <= 1'b0;
            end else begin
                r_o_grp <= '0;
                r_o_own <= '0;
                r_o_nb  <= '0;
                r_o_hn  <= 1'b0;
                r_o_ca  <= '0;
                r_o_cb  <= '0;
                r_o_cc  <= '0;
                r_o_cd  <= '0;
                r_o_hx  <= '0;
                r_o_hy  <= '0;
                r_o_hz  <= '0;
                r_o_oor <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_v[ST_O];
    assign o_m_tdata  = M_DATA_W'({r_o_hz, r_o_hy, r_o_hx, r_o_cd, r_o_cc, r_o_cb,
                                   r_o_ca, r_o_nb, r_o_own});
    assign o_m_tuser  = {r_o_oor, r_o_hn, r_o_grp};

endmodule

// ===== hw/rtl/hgfc_checker.sv =====
// Port-level checks for hex_grid_face_connectivity, bound to the top level.
// Depends on hgfc_pkg for the port widths.
module hgfc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [hgfc_pkg::M_DATA_W-1:0]  o_m_tdata,
    input logic [hgfc_pkg::M_USER_W-1:0]  o_m_tuser
);
    import hgfc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("master word changed while stalled");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[5] |-> o_m_tdata == '0 && o_m_tuser[4:0] == '0)
        else $error("out of range word carries nonzero fields");

    a_nb_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[4] |-> o_m_tuser[3:0] <= GRP_W'(G_INT_Z))
        else $error("neighbour flagged on boundary group");

    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_tready)
        else $error("input ready right after config write");

endmodule

bind hex_grid_face_connectivity hgfc_checker u_hgfc_checker (.*);

// ===== bench/tb_hex_grid_face_connectivity.sv =====
`timescale 1ns / 1ps
// Testbench for hex_grid_face_connectivity: streams face numbers through several grid
// sizes and checks each result word against typed values or a face indexing predictor.
// Depends on hgfc_pkg and the block RTL.
module tb_hex_grid_face_connectivity;
    import hgfc_pkg::*;

    typedef struct packed {
        t_group             grp;
        logic [CELL_W-1:0]  owner;
        logic [CELL_W-1:0]  nbr;
        logic               has_nbr;
        logic [PT_W-1:0]    ca;
        logic [PT_W-1:0]    cb;
        logic [PT_W-1:0]    cc;
        logic [PT_W-1:0]    cd;
        logic [HALF_W-1:0]  hx;
        logic [HALF_W-1:0]  hy;
        logic [HALF_W-1:0]  hz;
        logic               oor;
    } t_face_info;

    typedef struct {
        logic [FACE_W-1:0] face;
        bit                typed;
        t_face_info        want;
    } t_row;

    localparam int WATCHDOG = 5000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = CFG_CELLS_X;
    logic [CFG_DW-1:0]    i_cfg_wdata = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic [M_USER_W-1:0]  o_m_tuser;

    hex_grid_face_connectivity DUT (.*);

    always #6 i_clk = ~i_clk;

    logic [CFG_DW-1:0] grid_x = 9'd1, grid_y = 9'd1, grid_z = 9'd1;
    t_face_info        pending_faces[$];
    bit                cur_typed;
    t_face_info        cur_want;
    int                errors = 0;
    int                idle_cycles = 0;
    int                hold_req = 0;
    bit                no_gaps = 0;

    function automatic longint unsigned axis_eff(logic [CFG_DW-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_CELLS_PER_AXIS) return MAX_CELLS_PER_AXIS;
        return v;
    endfunction

    function automatic void group_dims(int g, output longint unsigned a, b, c);
        longint unsigned nx, ny, nz;
        nx = axis_eff(grid_x); ny = axis_eff(grid_y); nz = axis_eff(grid_z);
        c = 1;
        case (g)
            0: begin a = nx - 1; b = ny; c = nz; end
            1: begin a = nx; b = ny - 1; c = nz; end
            2: begin a = nx; b = ny; c = nz - 1; end
            3, 4: begin a = ny; b = nz; end
            5, 6: begin a = nx; b = nz; end
            default: begin a = nx; b = ny; end
        endcase
    endfunction

    function automatic longint unsigned group_start(int g);
        longint unsigned s, a, b, c;
        s = 0;
        for (int n = 0; n < g; n++) begin
            group_dims(n, a, b, c);
            s += a * b * c;
        end
        return s;
    endfunction

    function automatic t_face_info locate_face(logic [FACE_W-1:0] face);
        t_face_info r;
        longint unsigned nx, ny, nz, px, pxy, rem, a, b, c, i, j, k, own, p;
        int g;
        nx = axis_eff(grid_x); ny = axis_eff(grid_y); nz = axis_eff(grid_z);
        px = nx + 1; pxy = (nx + 1) * (ny + 1);
        rem = face;
        r = '0;
        for (g = 0; g < NUM_GROUPS; g++) begin
            group_dims(g, a, b, c);
            if (rem < a * b * c) break;
            rem -= a * b * c;
        end
        if (g == NUM_GROUPS) begin
            r.oor = 1'b1;
            return r;
        end
        i = rem % a; j = (rem / a) % b; k = rem / (a * b);
        if (g == 3 || g == 4) begin
            k = j; j = i; i = (g == 3) ? 0 : nx - 1;
        end else if (g == 5 || g == 6) begin
            k = j; j = (g == 5) ? 0 : ny - 1;
        end else if (g >= 7) begin
            k = (g == 7) ? 0 : nz - 1;
        end
        own = k * nx * ny + j * nx + i;
        p = k * pxy + j * px + i;
        r.grp = t_group'(g);
        r.owner = CELL_W'(own);
        r.has_nbr = (g <= 2);
        r.hx = HALF_W'(2 * i + 1); r.hy = HALF_W'(2 * j + 1); r.hz = HALF_W'(2 * k + 1);
        case (g)
            0: begin r.nbr = CELL_W'(own + 1); r.hx = HALF_W'(2 * (i + 1)); p += 1; end
            1: begin r.nbr = CELL_W'(own + nx); r.hy = HALF_W'(2 * (j + 1)); p += px; end
            2: begin
                r.nbr = CELL_W'(own + nx * ny); r.hz = HALF_W'(2 * (k + 1)); p += pxy;
            end
            3: r.hx = '0;
            4: begin r.hx = HALF_W'(2 * nx); p += 1; end
            5: r.hy = '0;
            6: begin r.hy = HALF_W'(2 * ny); p += px; end
            7: r.hz = '0;
            default: begin r.hz = HALF_W'(2 * nz); p += pxy; end
        endcase
        r.ca = PT_W'(p);
        if (g == 0 || g == 3 || g == 4) begin
            r.cb = PT_W'(p + px); r.cc = PT_W'(p + px + pxy); r.cd = PT_W'(p + pxy);
        end else if (g == 1 || g == 5 || g == 6) begin
            r.cb = PT_W'(p + 1); r.cc = PT_W'(p + 1 + pxy); r.cd = PT_W'(p + pxy);
        end else begin
            r.cb = PT_W'(p + 1); r.cc = PT_W'(p + 1 + px); r.cd = PT_W'(p + px);
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want, got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_face_info want, got;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pending_faces = {pending_faces,
                             cur_typed ? cur_want : locate_face(i_s_tdata[FACE_W-1:0])};
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.owner = o_m_tdata[23:0];
            got.nbr = o_m_tdata[47:24];
            got.ca = o_m_tdata[72:48];
            got.cb = o_m_tdata[97:73];
            got.cc = o_m_tdata[122:98];
            got.cd = o_m_tdata[147:123];
            got.hx = o_m_tdata[157:148];
            got.hy = o_m_tdata[167:158];
            got.hz = o_m_tdata[177:168];
            got.grp = t_group'(o_m_tuser[3:0]);
            got.has_nbr = o_m_tuser[4];
            got.oor = o_m_tuser[5];
            if (pending_faces.size() == 0) begin
                $display("%0t unexpected result word, group %0d", $time, got.grp);
                errors++;
            end else begin
                want = pending_faces.pop_front();
                check_field("face_group", want.grp, got.grp);
                check_field("owner_cell", want.owner, got.owner);
                check_field("neighbour_cell", want.nbr, got.nbr);
                check_field("has_neighbour", want.has_nbr, got.has_nbr);
                check_field("corner_a", want.ca, got.ca);
                check_field("corner_b", want.cb, got.cb);
                check_field("corner_c", want.cc, got.cc);
                check_field("corner_d", want.cd, got.cd);
                check_field("centre_x_half", want.hx, got.hx);
                check_field("centre_y_half", want.hy, got.hy);
                check_field("centre_z_half", want.hz, got.hz);
                check_field("out_of_range", want.oor, got.oor);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n
            || pending_faces.size() == 0 && !i_s_tvalid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random back-pressure (none in no-gap runs), with a long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                i_m_tready = 1'b0;
                hold--;
            end else if (no_gaps) begin
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = (pick_gap() == 0);
            end
        end
    end

    task automatic send_face(logic [FACE_W-1:0] face, bit typed, t_face_info want);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = {{(S_DATA_W-FACE_W){1'b0}}, face};
        cur_typed = typed;
        cur_want = want;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic set_grid(logic [CFG_DW-1:0] x, y, z);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        cur_typed = 0;
        while (pending_faces.size() != 0) @(negedge i_clk);
        repeat (25) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = CFG_CELLS_X; i_cfg_wdata = x;
        @(negedge i_clk);
        i_cfg_addr = CFG_CELLS_Y; i_cfg_wdata = y;
        @(negedge i_clk);
        i_cfg_addr = CFG_CELLS_Z; i_cfg_wdata = z;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        grid_x = x; grid_y = y; grid_z = z;
    endtask

    function automatic logic [FACE_W-1:0] random_face();
        int r, g;
        longint unsigned total, f;
        total = group_start(NUM_GROUPS);
        r = $urandom_range(0, 99);
        if (r < 20) begin
            g = $urandom_range(0, NUM_GROUPS);
            f = group_start(g) + $urandom_range(0, 2);
            if (f > 0 && $urandom_range(0, 1)) f -= $urandom_range(1, 2);
        end else if (r < 28) begin
            f = $urandom & 32'h3FF_FFFF;
        end else if (r < 32) begin
            f = total + $urandom_range(0, 1000);
        end else begin
            f = ({$urandom, $urandom} % total);
        end
        return f[FACE_W-1:0];
    endfunction

    t_row       directed[$];
    int         grid_list[][3];
    t_face_info blank;

    initial begin
        t_row row;
        blank = '0;
        // single cell: only the six boundary faces exist
        row = '{26'd0, 1, '{G_LEFT, 24'd0, 24'd0, 1'b0, 25'd0, 25'd2, 25'd6, 25'd4,
                10'd0, 10'd1, 10'd1, 1'b0}};
        directed = {directed, row};
        for (int f = 1; f <= 4; f++) begin
            row.face = FACE_W'(f);
            row.typed = 0;
            row.want = blank;
            directed = {directed, row};
        end
        row = '{26'd5, 1, '{G_BACK, 24'd0, 24'd0, 1'b0, 25'd4, 25'd5, 25'd7, 25'd6,
                10'd1, 10'd1, 10'd2, 1'b0}};
        directed = {directed, row};
        row = '{26'd6, 1, '{G_INT_X, 24'd0, 24'd0, 1'b0, 25'd0, 25'd0, 25'd0, 25'd0,
                10'd0, 10'd0, 10'd0, 1'b1}};
        directed = {directed, row};
        row.face = 26'h3FF_FFFF;
        directed = {directed, row};
        row.face = 26'h155_5555;
        directed = {directed, row};

        grid_list = '{'{256, 256, 256}, '{0, 511, 3}, '{2, 1, 1}, '{1, 2, 1}, '{1, 1, 2},
                      '{7, 5, 3}, '{300, 1, 256}, '{0, 0, 0}, '{-1, -1, -1}, '{-1, -1, -1}};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[n])
            send_face(directed[n].face, directed[n].typed, directed[n].want);

        foreach (grid_list[p]) begin
            logic [CFG_DW-1:0] gx, gy, gz;
            gx = CFG_DW'((grid_list[p][0] < 0) ? $urandom_range(1, 40) : grid_list[p][0]);
            gy = CFG_DW'((grid_list[p][1] < 0) ? $urandom_range(1, 40) : grid_list[p][1]);
            gz = CFG_DW'((grid_list[p][2] < 0) ? $urandom_range(1, 40) : grid_list[p][2]);
            set_grid(gx, gy, gz);
            no_gaps = (p == 3);
            if (p == 0) begin
                // extremes of the largest grid, then a long receiver hold-off
                for (int g = 0; g <= NUM_GROUPS; g++) begin
                    send_face(FACE_W'(group_start(g)), 0, blank);
                    if (g > 0) send_face(FACE_W'(group_start(g) - 1), 0, blank);
                end
                hold_req = 300;
            end
            repeat (155) send_face(random_face(), 0, blank);
            no_gaps = 0;
        end

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_faces.size() != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_faces.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
